// ===== hdl/fsjw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsjw_pkg
// shared constants, command, status and thread state codes, sequencer states
// ----------------------------------------------------------------------------
package fsjw_pkg;

  localparam int unsigned THREADS_DEF     = 64;
  localparam int unsigned READY_DEPTH_DEF = 64;
  localparam int unsigned WAIT_DEPTH_DEF  = 64;
  localparam int unsigned TID_W           = 6;
  localparam int unsigned JOB_W           = 64;

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_SUSPEND  = 2'd1,
    CMD_RESUME   = 2'd2,
    CMD_SCHEDULE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_IDLE     = 2'd1,
    STS_NOTFOUND = 2'd2,
    STS_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TS_NONE      = 2'd0,
    TS_READY     = 2'd1,
    TS_RUNNING   = 2'd2,
    TS_SUSPENDED = 2'd3
  } tstate_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_REQ,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUSH,
    S_POP_RD,
    S_POP_WAIT,
    S_POP_DONE,
    S_STATE_RD,
    S_STATE_WAIT,
    S_RESP
  } state_e;

endpackage : fsjw_pkg
`default_nettype wire

// ===== hdl/fsjw_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsjw_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module fsjw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : fsjw_ram
`default_nettype wire

// ===== hdl/fifo_scheduler_with_job_wait_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_scheduler_with_job_wait_list
// thread scheduler: fifo ready queue plus ordered job wait list
// ----------------------------------------------------------------------------
// latency from the accepting edge to the result beat follows the states passed:
//   suspend dispatch; enqueue dispatch, push; dropped enqueue or suspend dispatch, state
//   read; schedule dispatch, pop; resume search request and compare per wait entry,
//   shift read and write per entry moved in compaction, push or, if full, state read
// one command at a time; in_ready is high only in idle, entered the cycle after
//   the result beat is taken, so no new command is accepted before then
// the wait list ram port and the single job compare set the resume time
// reset clears counters, pointers, current thread and the per-thread
//   state valid bits; no clearing pass is needed
module fifo_scheduler_with_job_wait_list #(
  parameter int unsigned THREADS     = fsjw_pkg::THREADS_DEF,
  parameter int unsigned READY_DEPTH = fsjw_pkg::READY_DEPTH_DEF,
  parameter int unsigned WAIT_DEPTH  = fsjw_pkg::WAIT_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [fsjw_pkg::TID_W-1:0]  thread_id_i,
  input  wire logic [fsjw_pkg::JOB_W-1:0]  job_id_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [fsjw_pkg::TID_W-1:0]       out_thread_o,
  output logic                             out_thread_valid_o,
  output logic [1:0]                       status_o,
  output logic [1:0]                       out_thread_state_o
);

  localparam int unsigned RA_W = $clog2(READY_DEPTH);
  localparam int unsigned WA_W = $clog2(WAIT_DEPTH);
  localparam int unsigned TA_W = $clog2(THREADS);
  localparam int unsigned RC_W = $clog2(READY_DEPTH + 1);
  localparam int unsigned WC_W = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned TW   = fsjw_pkg::TID_W;
  localparam int unsigned JW   = fsjw_pkg::JOB_W;

  fsjw_pkg::state_e state_q, state_d;

  // captured command beat
  logic [1:0]    cmd_q;
  logic [TW-1:0] tid_q, tid_d;
  logic [JW-1:0] job_q;

  // queue and list bookkeeping
  logic [RA_W-1:0] rhead_q, rhead_d, rtail_q, rtail_d;
  logic [RC_W-1:0] rcount_q, rcount_d;
  logic [WC_W-1:0] wcount_q, wcount_d;
  logic [WC_W-1:0] idx_q, idx_d;   // search / compaction pointer
  logic [TW-1:0]   cur_q, cur_d;
  logic            curv_q, curv_d;

  // result holding register
  logic          ovalid_q, ovalid_d;
  logic [TW-1:0] othr_q, othr_d;
  logic          otv_q, otv_d;
  logic [1:0]    osts_q, osts_d;
  logic [1:0]    ost_q, ost_d;

  // per-thread state: ram plus valid bits (unwritten reads as none)
  logic [THREADS-1:0] tsv_q, tsv_d;

  // ram ports
  logic            rq_we;
  logic [RA_W-1:0] rq_waddr, rq_raddr;
  logic [TW-1:0]   rq_wdata, rq_rdata;
  logic            wt_we;
  logic [WA_W-1:0] wl_waddr, wl_raddr;
  logic [TW-1:0]   wt_wdata, wt_rdata;
  logic [JW-1:0]   wj_wdata, wj_rdata;
  logic            ts_we;
  logic [TA_W-1:0] ts_waddr, ts_raddr;
  logic [1:0]      ts_wdata, ts_rdata;

  logic rq_full, wl_full, tid_in_range;
  logic [TA_W-1:0] tid_idx;

  assign rq_full      = (rcount_q == RC_W'(READY_DEPTH));
  assign wl_full      = (wcount_q == WC_W'(WAIT_DEPTH));
  assign tid_in_range = ({{(32-TW){1'b0}}, tid_q} < THREADS);
  assign tid_idx      = TA_W'(tid_q);

  fsjw_ram #(.WIDTH(TW), .DEPTH(READY_DEPTH)) u_ready (
    .clk_i, .we_i(rq_we), .waddr_i(rq_waddr), .wdata_i(rq_wdata),
    .raddr_i(rq_raddr), .rdata_o(rq_rdata)
  );
  fsjw_ram #(.WIDTH(TW), .DEPTH(WAIT_DEPTH)) u_wthr (
    .clk_i, .we_i(wt_we), .waddr_i(wl_waddr), .wdata_i(wt_wdata),
    .raddr_i(wl_raddr), .rdata_o(wt_rdata)
  );
  fsjw_ram #(.WIDTH(JW), .DEPTH(WAIT_DEPTH)) u_wjob (
    .clk_i, .we_i(wt_we), .waddr_i(wl_waddr), .wdata_i(wj_wdata),
    .raddr_i(wl_raddr), .rdata_o(wj_rdata)
  );
  fsjw_ram #(.WIDTH(2), .DEPTH(THREADS)) u_tstate (
    .clk_i, .we_i(ts_we), .waddr_i(ts_waddr), .wdata_i(ts_wdata),
    .raddr_i(ts_raddr), .rdata_o(ts_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fsjw_pkg::S_IDLE;
      rhead_q  <= '0;
      rtail_q  <= '0;
      rcount_q <= '0;
      wcount_q <= '0;
      cur_q    <= '0;
      curv_q   <= 1'b0;
      ovalid_q <= 1'b0;
      tsv_q    <= '0;
    end else begin
      state_q  <= state_d;
      rhead_q  <= rhead_d;
      rtail_q  <= rtail_d;
      rcount_q <= rcount_d;
      wcount_q <= wcount_d;
      cur_q    <= cur_d;
      curv_q   <= curv_d;
      ovalid_q <= ovalid_d;
      tsv_q    <= tsv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_i;
      job_q <= job_id_i;
    end
    tid_q    <= tid_d;
    idx_q    <= idx_d;
    othr_q   <= othr_d;
    otv_q    <= otv_d;
    osts_q   <= osts_d;
    ost_q    <= ost_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsjw_pkg::S_IDLE:
        if (in_valid_i) state_d = fsjw_pkg::S_DISPATCH;
      fsjw_pkg::S_DISPATCH: begin
        unique case (fsjw_pkg::cmd_e'(cmd_q))
          fsjw_pkg::CMD_ENQUEUE:
            state_d = rq_full ? fsjw_pkg::S_STATE_RD : fsjw_pkg::S_PUSH;
          fsjw_pkg::CMD_SUSPEND:
            state_d = wl_full ? fsjw_pkg::S_STATE_RD : fsjw_pkg::S_RESP;
          fsjw_pkg::CMD_RESUME:
            state_d = (wcount_q == '0) ? fsjw_pkg::S_RESP : fsjw_pkg::S_SRCH_REQ;
          default:
            state_d = (rcount_q == '0) ? fsjw_pkg::S_RESP : fsjw_pkg::S_POP_RD;
        endcase
      end
      fsjw_pkg::S_SRCH_REQ: state_d = fsjw_pkg::S_SRCH_CMP;
      fsjw_pkg::S_SRCH_CMP: begin
        if (wj_rdata == job_q) begin
          if (rq_full) state_d = fsjw_pkg::S_STATE_RD;
          else if (idx_q + 1'b1 < wcount_q) state_d = fsjw_pkg::S_SHIFT_RD;
          else state_d = fsjw_pkg::S_PUSH;
        end else if (idx_q == '0) begin
          state_d = fsjw_pkg::S_RESP;
        end else begin
          state_d = fsjw_pkg::S_SRCH_REQ;
        end
      end
      fsjw_pkg::S_SHIFT_RD: state_d = fsjw_pkg::S_SHIFT_WR;
      fsjw_pkg::S_SHIFT_WR:
        state_d = (idx_q + 1'b1 < wcount_q) ? fsjw_pkg::S_SHIFT_RD : fsjw_pkg::S_PUSH;
      fsjw_pkg::S_PUSH:     state_d = fsjw_pkg::S_RESP;
      fsjw_pkg::S_POP_RD:   state_d = fsjw_pkg::S_POP_WAIT;
      fsjw_pkg::S_POP_WAIT: state_d = fsjw_pkg::S_POP_DONE;
      fsjw_pkg::S_POP_DONE: state_d = fsjw_pkg::S_RESP;
      fsjw_pkg::S_STATE_RD: state_d = fsjw_pkg::S_STATE_WAIT;
      fsjw_pkg::S_STATE_WAIT: state_d = fsjw_pkg::S_RESP;
      fsjw_pkg::S_RESP:
        if (out_ready_i) state_d = fsjw_pkg::S_IDLE;
      default: state_d = fsjw_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rhead_d  = rhead_q;
    rtail_d  = rtail_q;
    rcount_d = rcount_q;
    wcount_d = wcount_q;
    idx_d    = idx_q;
    tid_d    = tid_q;
    cur_d    = cur_q;
    curv_d   = curv_q;
    ovalid_d = ovalid_q;
    othr_d   = othr_q;
    otv_d    = otv_q;
    osts_d   = osts_q;
    ost_d    = ost_q;
    tsv_d    = tsv_q;
    rq_we    = 1'b0;
    rq_waddr = rtail_q;
    rq_wdata = tid_q;
    rq_raddr = rhead_q;
    wt_we    = 1'b0;
    wl_waddr = WA_W'(wcount_q);
    wt_wdata = tid_q;
    wj_wdata = job_q;
    wl_raddr = WA_W'(idx_q);
    ts_we    = 1'b0;
    ts_waddr = tid_idx;
    ts_wdata = fsjw_pkg::TS_READY;
    ts_raddr = tid_idx;
    in_ready_o = 1'b0;

    unique case (state_q)
      fsjw_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        tid_d      = thread_id_i;
      end
      fsjw_pkg::S_DISPATCH: begin
        othr_d = tid_q;
        otv_d  = 1'b1;
        osts_d = fsjw_pkg::STS_OK;
        unique case (fsjw_pkg::cmd_e'(cmd_q))
          fsjw_pkg::CMD_ENQUEUE:
            if (rq_full) osts_d = fsjw_pkg::STS_FULL;
          fsjw_pkg::CMD_SUSPEND: begin
            if (wl_full) begin
              osts_d = fsjw_pkg::STS_FULL;
            end else begin
              wt_we    = 1'b1;
              wcount_d = wcount_q + 1'b1;
              ost_d    = fsjw_pkg::TS_SUSPENDED;
              if (tid_in_range) begin
                ts_we    = 1'b1;
                ts_wdata = fsjw_pkg::TS_SUSPENDED;
                tsv_d[tid_idx] = 1'b1;
              end
            end
          end
          fsjw_pkg::CMD_RESUME: begin
            idx_d = wcount_q - 1'b1;
            if (wcount_q == '0) begin
              othr_d = '0;
              otv_d  = 1'b0;
              osts_d = fsjw_pkg::STS_NOTFOUND;
              ost_d  = fsjw_pkg::TS_NONE;
            end
          end
          default:
            if (rcount_q == '0) begin
              othr_d = '0;
              otv_d  = 1'b0;
              osts_d = fsjw_pkg::STS_IDLE;
              ost_d  = fsjw_pkg::TS_NONE;
            end
        endcase
      end
      fsjw_pkg::S_SRCH_REQ: ;
      fsjw_pkg::S_SRCH_CMP: begin
        if (wj_rdata == job_q) begin
          tid_d  = wt_rdata;
          othr_d = wt_rdata;
          otv_d  = 1'b1;
          if (rq_full) osts_d = fsjw_pkg::STS_FULL;
          else wcount_d = wcount_q - 1'b1;
        end else if (idx_q == '0) begin
          othr_d = '0;
          otv_d  = 1'b0;
          osts_d = fsjw_pkg::STS_NOTFOUND;
          ost_d  = fsjw_pkg::TS_NONE;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      // wcount already reduced by one: move entries idx+1 down while idx+1 <= wcount
      fsjw_pkg::S_SHIFT_RD: wl_raddr = WA_W'(idx_q + 1'b1);
      fsjw_pkg::S_SHIFT_WR: begin
        wt_we    = 1'b1;
        wl_waddr = WA_W'(idx_q);
        wt_wdata = wt_rdata;
        wj_wdata = wj_rdata;
        idx_d    = idx_q + 1'b1;
      end
      fsjw_pkg::S_PUSH: begin
        rq_we    = 1'b1;
        rtail_d  = (rtail_q == RA_W'(READY_DEPTH - 1)) ? '0 : rtail_q + 1'b1;
        rcount_d = rcount_q + 1'b1;
        ost_d    = fsjw_pkg::TS_READY;
        if (tid_in_range) begin
          ts_we = 1'b1;
          tsv_d[tid_idx] = 1'b1;
        end
      end
      fsjw_pkg::S_POP_RD: begin
        rhead_d  = (rhead_q == RA_W'(READY_DEPTH - 1)) ? '0 : rhead_q + 1'b1;
        rcount_d = rcount_q - 1'b1;
      end
      fsjw_pkg::S_POP_WAIT: tid_d = rq_rdata;
      fsjw_pkg::S_POP_DONE: begin
        othr_d = tid_q;
        otv_d  = 1'b1;
        osts_d = fsjw_pkg::STS_OK;
        ost_d  = fsjw_pkg::TS_RUNNING;
        cur_d  = tid_q;
        curv_d = 1'b1;
        if (tid_in_range) begin
          ts_we    = 1'b1;
          ts_wdata = fsjw_pkg::TS_RUNNING;
          tsv_d[tid_idx] = 1'b1;
        end
      end
      fsjw_pkg::S_STATE_RD: ;
      fsjw_pkg::S_STATE_WAIT: begin
        if (tid_in_range && tsv_q[tid_idx]) ost_d = ts_rdata;
        else ost_d = fsjw_pkg::TS_NONE;
      end
      fsjw_pkg::S_RESP: ;
      default: ;
    endcase

    ovalid_d = (state_d == fsjw_pkg::S_RESP);
  end

  assign out_valid_o        = ovalid_q;
  assign out_thread_o       = othr_q;
  assign out_thread_valid_o = otv_q;
  assign status_o           = osts_q;
  assign out_thread_state_o = ost_q;

  // current thread is tracked but not reported
  logic unused_cur;
  assign unused_cur = ^{cur_q, curv_q};

endmodule : fifo_scheduler_with_job_wait_list
`default_nettype wire

// ===== sim/fifo_scheduler_with_job_wait_list_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_scheduler_with_job_wait_list_test
// drives scheduler commands, tracks queue and wait list state in a model of
// its own and checks every result beat field by field, in order
// ----------------------------------------------------------------------------
module fifo_scheduler_with_job_wait_list_test;

  localparam int unsigned NTHR  = 64;
  localparam int unsigned RDEP  = 64;
  localparam int unsigned WDEP  = 64;
  localparam int unsigned LIMIT = 2000000;

  typedef struct packed {
    logic [5:0]        thr;
    logic              vld;
    fsjw_pkg::status_e sts;
    fsjw_pkg::tstate_e tst;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = '0;
  logic [5:0]  thread_id_i = '0;
  logic [63:0] job_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  out_thread_o;
  logic        out_thread_valid_o;
  logic [1:0]  status_o;
  logic [1:0]  out_thread_state_o;

  fifo_scheduler_with_job_wait_list dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .thread_id_i, .job_id_i,
    .out_valid_o, .out_ready_i, .out_thread_o, .out_thread_valid_o, .status_o,
    .out_thread_state_o
  );

  always #10 clk_i = ~clk_i;

  // scheduler model state
  logic [5:0]        rq_slot [RDEP];
  int unsigned       rq_head, rq_tail, rq_count;
  logic [5:0]        wl_thr [WDEP];
  logic [63:0]       wl_job [WDEP];
  int unsigned       wl_count;
  fsjw_pkg::tstate_e thr_state [NTHR];
  logic [5:0]        cur_thr;
  logic              cur_vld;

  sched_result_t expected_q[$];
  int unsigned   errors = 0;
  longint        cycle = 0;
  bit            idle_gaps = 1'b1;  // random idling on both sides
  bit            hold_off = 1'b0;   // receiver long stall
  logic [63:0]   used_jobs[$];

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycle, what);
  endtask

  function automatic void model_reset();
    rq_head = 0; rq_tail = 0; rq_count = 0; wl_count = 0;
    cur_thr = '0; cur_vld = 1'b0;
    for (int i = 0; i < NTHR; i++) thr_state[i] = fsjw_pkg::TS_NONE;
  endfunction

  function automatic sched_result_t schedule_step(fsjw_pkg::cmd_e c, logic [5:0] t,
                                                  logic [63:0] j);
    sched_result_t r;
    int i;
    bit hit;
    logic [5:0] w;
    hit = 1'b0;
    r = '{thr: 6'd0, vld: 1'b0, sts: fsjw_pkg::STS_OK, tst: fsjw_pkg::TS_NONE};
    case (c)
      fsjw_pkg::CMD_ENQUEUE: begin
        r.thr = t; r.vld = 1'b1;
        if (rq_count >= RDEP) begin
          r.sts = fsjw_pkg::STS_FULL; r.tst = thr_state[t];
        end else begin
          rq_slot[rq_tail] = t; rq_tail = (rq_tail + 1) % RDEP; rq_count++;
          thr_state[t] = fsjw_pkg::TS_READY; r.tst = fsjw_pkg::TS_READY;
        end
      end
      fsjw_pkg::CMD_SUSPEND: begin
        r.thr = t; r.vld = 1'b1;
        if (wl_count >= WDEP) begin
          r.sts = fsjw_pkg::STS_FULL; r.tst = thr_state[t];
        end else begin
          wl_thr[wl_count] = t; wl_job[wl_count] = j; wl_count++;
          thr_state[t] = fsjw_pkg::TS_SUSPENDED; r.tst = fsjw_pkg::TS_SUSPENDED;
        end
      end
      fsjw_pkg::CMD_RESUME: begin
        // newest entry first
        for (i = int'(wl_count) - 1; i >= 0; i--) begin
          if (wl_job[i] == j) begin
            hit = 1'b1;
            break;
          end
        end
        if (!hit) begin
          r.sts = fsjw_pkg::STS_NOTFOUND;
        end else begin
          w = wl_thr[i];
          r.thr = w; r.vld = 1'b1;
          if (rq_count >= RDEP) begin
            r.sts = fsjw_pkg::STS_FULL; r.tst = thr_state[w];
          end else begin
            for (; i + 1 < int'(wl_count); i++) begin
              wl_thr[i] = wl_thr[i+1]; wl_job[i] = wl_job[i+1];
            end
            wl_count--;
            rq_slot[rq_tail] = w; rq_tail = (rq_tail + 1) % RDEP; rq_count++;
            thr_state[w] = fsjw_pkg::TS_READY; r.tst = fsjw_pkg::TS_READY;
          end
        end
      end
      default: begin
        if (rq_count == 0) begin
          r.sts = fsjw_pkg::STS_IDLE;
        end else begin
          w = rq_slot[rq_head]; rq_head = (rq_head + 1) % RDEP; rq_count--;
          thr_state[w] = fsjw_pkg::TS_RUNNING; cur_thr = w; cur_vld = 1'b1;
          r.thr = w; r.vld = 1'b1; r.tst = fsjw_pkg::TS_RUNNING;
        end
      end
    endcase
    return r;
  endfunction

  // one input beat: optional random gap, then hold valid until accepted
  task automatic send_cmd(input fsjw_pkg::cmd_e c, input logic [5:0] t,
                          input logic [63:0] j);
    if (idle_gaps && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (idle_gaps && $urandom_range(99) < 33) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    thread_id_i <= t;
    job_id_i    <= j;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q.push_back(schedule_step(c, t, j));
    if (c == fsjw_pkg::CMD_SUSPEND) used_jobs.push_back(j);
  endtask

  // receiver ready, sampled one step after the edge
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    out_ready_i <= !hold_off && !(idle_gaps && $urandom_range(99) < 33);
  end

  // result checker
  always @(posedge clk_i) begin
    sched_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        e = expected_q.pop_front();
        if (out_thread_o !== e.thr)
          report($sformatf("thread %0d, want %0d", out_thread_o, e.thr));
        if (out_thread_valid_o !== e.vld)
          report($sformatf("thread valid %0b, want %0b", out_thread_valid_o, e.vld));
        if (status_o !== e.sts)
          report($sformatf("status %0d, want %0d", status_o, e.sts));
        if (out_thread_state_o !== e.tst)
          report($sformatf("state %0d, want %0d", out_thread_state_o, e.tst));
      end
    end
  end

  function automatic logic [63:0] rand_job();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_job();
    if (used_jobs.size() != 0 && $urandom_range(99) < 80)
      return used_jobs[$urandom_range(used_jobs.size() - 1)];
    return rand_job();
  endfunction

  // field extremes, each command, empty and not-found cases
  task automatic test_directed();
    send_cmd(fsjw_pkg::CMD_SCHEDULE, 6'd0, 64'd0);        // empty queue
    send_cmd(fsjw_pkg::CMD_RESUME, 6'd5, 64'd0);          // empty wait list
    send_cmd(fsjw_pkg::CMD_ENQUEUE, 6'd0, 64'd0);
    send_cmd(fsjw_pkg::CMD_ENQUEUE, 6'd63, '1);
    send_cmd(fsjw_pkg::CMD_ENQUEUE, 6'd63, 64'd0);        // repeated thread
    send_cmd(fsjw_pkg::CMD_SUSPEND, 6'd63, '1);
    send_cmd(fsjw_pkg::CMD_SUSPEND, 6'd0, 64'd0);
    send_cmd(fsjw_pkg::CMD_SUSPEND, 6'd42, '1);           // duplicate job id
    send_cmd(fsjw_pkg::CMD_RESUME, 6'd0, '1);             // takes newest match
    send_cmd(fsjw_pkg::CMD_RESUME, 6'd0, 64'h5555_aaaa_5555_aaaa);
    send_cmd(fsjw_pkg::CMD_RESUME, 6'd21, 64'd0);
    send_cmd(fsjw_pkg::CMD_RESUME, 6'd0, '1);
    for (int i = 0; i < 6; i++) send_cmd(fsjw_pkg::CMD_SCHEDULE, 6'd0, 64'd0);
  endtask

  // fill both stores past capacity, including resume with full ready queue
  task automatic test_full_stores();
    for (int i = 0; i < WDEP + 2; i++)
      send_cmd(fsjw_pkg::CMD_SUSPEND, 6'(i), 64'(i + 100));
    for (int i = 0; i < RDEP + 2; i++)
      send_cmd(fsjw_pkg::CMD_ENQUEUE, 6'($urandom), rand_job());
    send_cmd(fsjw_pkg::CMD_RESUME, 6'd0, 64'd130);        // match but queue full
    for (int i = 0; i < 10; i++) send_cmd(fsjw_pkg::CMD_SCHEDULE, 6'd0, 64'd0);
    for (int i = 0; i < 12; i++)
      send_cmd(fsjw_pkg::CMD_RESUME, 6'd0, 64'(100 + $urandom_range(70)));
    while (rq_count > 0) send_cmd(fsjw_pkg::CMD_SCHEDULE, 6'd0, 64'd0);
    while (wl_count > 0)
      send_cmd(fsjw_pkg::CMD_RESUME, 6'd0, wl_job[$urandom_range(wl_count - 1)]);
    while (rq_count > 0) send_cmd(fsjw_pkg::CMD_SCHEDULE, 6'd0, 64'd0);
  endtask

  // receiver stalls for a long stretch while commands keep being offered
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 20; i++)
      send_cmd(fsjw_pkg::cmd_e'($urandom_range(3)), 6'($urandom), pick_job());
  endtask

  // random commands; resumes mostly name jobs already suspended, plus random noise
  task automatic test_random(input int unsigned n);
    fsjw_pkg::cmd_e c;
    for (int unsigned k = 0; k < n; k++) begin
      if (k == n / 3) idle_gaps = 1'b0;
      if (k == n / 3 + 120) idle_gaps = 1'b1;
      c = fsjw_pkg::cmd_e'($urandom_range(3));
      if (c == fsjw_pkg::CMD_RESUME) send_cmd(c, 6'($urandom), pick_job());
      else if (c == fsjw_pkg::CMD_SUSPEND && $urandom_range(1))
        send_cmd(c, 6'($urandom), 64'($urandom_range(15)));
      else send_cmd(c, 6'($urandom), rand_job());
      if (used_jobs.size() > 200) used_jobs.delete(0);
    end
  endtask

  initial begin
    model_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_stores();
    test_backpressure();
    test_random(340);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // timeout guard
  always @(posedge clk_i) begin
    if (cycle >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
